### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared wrappers for the concurrent checks of the text cell buffer
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is held
`define TCB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// clocked check that also covers the reset cycles
`define TCB_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/tcb_pkg.sv
// ----------------------------------------------------------------------------
// tcb_pkg
// sizes, codes and shared types of the text cell buffer
// ----------------------------------------------------------------------------
package tcb_pkg;

    // store geometry
    localparam int unsigned MAX_COLS = 128;
    localparam int unsigned MAX_ROWS = 64;
    localparam int unsigned COL_W    = $clog2(MAX_COLS);
    localparam int unsigned ROW_W    = $clog2(MAX_ROWS);
    localparam int unsigned COLS_W   = $clog2(MAX_COLS + 1);
    localparam int unsigned ROWS_W   = $clog2(MAX_ROWS + 1);
    localparam int unsigned ADDR_W   = COL_W + ROW_W;
    localparam int unsigned DEPTH    = MAX_COLS * MAX_ROWS;

    // field widths
    localparam int unsigned ACT_W    = 2;
    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned CDELTA_W = 8;
    localparam int unsigned RDELTA_W = 7;
    localparam int unsigned REG_W    = 2;
    localparam int unsigned DATA_W   = 8;

    // actions
    localparam logic [ACT_W-1:0] ACT_PUT  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SET  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_MOVE = 2'd2;
    localparam logic [ACT_W-1:0] ACT_READ = 2'd3;

    // special characters
    localparam logic [CHAR_W-1:0] CHAR_NUL = 8'd0;
    localparam logic [CHAR_W-1:0] CHAR_LF  = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_CR  = 8'd13;

    // register indexes
    localparam logic [REG_W-1:0] REG_COLS    = 2'd0;
    localparam logic [REG_W-1:0] REG_ROWS    = 2'd1;
    localparam logic [REG_W-1:0] REG_BG_CHAR = 2'd2;

    // register reset values
    localparam logic [COLS_W-1:0] COLS_RST    = 8'd80;
    localparam logic [ROWS_W-1:0] ROWS_RST    = 7'd25;
    localparam logic [CHAR_W-1:0] BG_CHAR_RST = 8'd32;

    // access to the character store for one word
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [CHAR_W-1:0] wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } t_mem_req;

    // refill request from the configuration side
    typedef struct packed {
        logic              start;
        logic [CHAR_W-1:0] fill_char;
    } t_fill;

endpackage

### rtl/core/tcb_ifs.sv
// ----------------------------------------------------------------------------
// tcb channel interfaces
// valid/ready channels for commands, results and register writes
// ----------------------------------------------------------------------------

// command channel
interface tcb_in_if;
    logic                                valid;
    logic                                ready;
    logic        [tcb_pkg::ACT_W-1:0]    action;
    logic        [tcb_pkg::CHAR_W-1:0]   char_code;
    logic        [tcb_pkg::COL_W-1:0]    col_index;
    logic        [tcb_pkg::ROW_W-1:0]    row_index;
    logic signed [tcb_pkg::CDELTA_W-1:0] col_delta;
    logic signed [tcb_pkg::RDELTA_W-1:0] row_delta;

    modport source (
        output valid, action, char_code, col_index, row_index, col_delta, row_delta,
        input  ready
    );
    modport sink (
        input  valid, action, char_code, col_index, row_index, col_delta, row_delta,
        output ready
    );
endinterface

// result channel
interface tcb_out_if;
    logic                         valid;
    logic                         ready;
    logic [tcb_pkg::CHAR_W-1:0]   cell_char;
    logic [tcb_pkg::COL_W-1:0]    cursor_col;
    logic [tcb_pkg::ROW_W-1:0]    cursor_row;

    modport source (
        output valid, cell_char, cursor_col, cursor_row,
        input  ready
    );
    modport sink (
        input  valid, cell_char, cursor_col, cursor_row,
        output ready
    );
endinterface

// register write channel
interface tcb_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [tcb_pkg::REG_W-1:0]    index;
    logic [tcb_pkg::DATA_W-1:0]   data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

### rtl/core/text_cell_buffer_cursor_writer_top.sv
// ----------------------------------------------------------------------------
// text_cell_buffer_cursor_writer_top
// character cell text buffer with cursor, left margin and cell read-back
// ----------------------------------------------------------------------------
// One command word goes in each cycle while the store is not refilling and the
// result side is not stalled, and one result word comes out per command: the
// command is held in an input register, the cursor update and the store access
// are worked out from it once the result stage can take a word, and the result
// register holds the new cursor and, for a read, the character from the store's
// registered read port. After reset, and after every write of the background
// character register, the store is refilled one location per cycle across all
// 8192 locations; during that sweep the command channel is not ready, while
// register writes are still taken. Registers are to be written only while no
// command is in flight.
module text_cell_buffer_cursor_writer_top (
    input logic        i_clk,
    input logic        i_rst_n,
    tcb_in_if.sink     i_in,
    tcb_out_if.source  o_out,
    tcb_cfg_if.sink    i_cfg
);

    typedef struct packed {
        logic        [tcb_pkg::ACT_W-1:0]    action;
        logic        [tcb_pkg::CHAR_W-1:0]   char_code;
        logic        [tcb_pkg::COL_W-1:0]    col_index;
        logic        [tcb_pkg::ROW_W-1:0]    row_index;
        logic signed [tcb_pkg::CDELTA_W-1:0] col_delta;
        logic signed [tcb_pkg::RDELTA_W-1:0] row_delta;
    } t_item;

    localparam int unsigned PCOL_W = tcb_pkg::COL_W + 3;
    localparam int unsigned PROW_W = tcb_pkg::ROW_W + 3;

    // configuration registers
    logic [tcb_pkg::COLS_W-1:0] r_cfg_cols;
    logic [tcb_pkg::ROWS_W-1:0] r_cfg_rows;
    logic [tcb_pkg::CHAR_W-1:0] r_bg_char;

    // input stage
    logic  r_in_v;
    t_item r_in;

    // cursor state
    logic [tcb_pkg::COL_W-1:0] r_cur_col, n_cur_col;
    logic [tcb_pkg::ROW_W-1:0] r_cur_row, n_cur_row;
    logic [tcb_pkg::COL_W-1:0] r_margin,  n_margin;

    // result stage
    logic                      r_out_v;
    logic                      r_out_rd;
    logic [tcb_pkg::COL_W-1:0] r_out_col;
    logic [tcb_pkg::ROW_W-1:0] r_out_row;

    logic                       cfg_acc;
    logic                       fire;
    logic                       store_busy;
    logic [tcb_pkg::CHAR_W-1:0] rd_data;
    tcb_pkg::t_mem_req          mem_req;
    tcb_pkg::t_fill             fill;

    logic [tcb_pkg::COLS_W-1:0] win_cols;
    logic [tcb_pkg::ROWS_W-1:0] win_rows;
    logic [tcb_pkg::COL_W-1:0]  cc, mc, ci;
    logic [tcb_pkg::ROW_W-1:0]  cr, ri;
    logic [tcb_pkg::COLS_W-1:0] col_inc;
    logic [tcb_pkg::ROWS_W-1:0] row_inc;
    logic [tcb_pkg::ROWS_W-1:0] put_row;
    logic signed [PCOL_W-1:0]   p_col;
    logic signed [PROW_W-1:0]   p_row;
    logic                       is_print;

    // clamp a column or row into the window
    function automatic logic [tcb_pkg::COL_W-1:0] sat_col(
        input logic [tcb_pkg::COL_W-1:0]  v,
        input logic [tcb_pkg::COLS_W-1:0] lim
    );
        logic [tcb_pkg::COLS_W-1:0] lim_m1;
        lim_m1  = lim - 1'b1;
        sat_col = ({1'b0, v} >= lim) ? lim_m1[tcb_pkg::COL_W-1:0] : v;
    endfunction

    function automatic logic [tcb_pkg::ROW_W-1:0] sat_row(
        input logic [tcb_pkg::ROW_W-1:0]  v,
        input logic [tcb_pkg::ROWS_W-1:0] lim
    );
        logic [tcb_pkg::ROWS_W-1:0] lim_m1;
        lim_m1  = lim - 1'b1;
        sat_row = ({1'b0, v} >= lim) ? lim_m1[tcb_pkg::ROW_W-1:0] : v;
    endfunction

    // register writes
    assign i_cfg.ready = 1'b1;
    assign cfg_acc     = i_cfg.valid && i_cfg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cols <= tcb_pkg::COLS_RST;
            r_cfg_rows <= tcb_pkg::ROWS_RST;
            r_bg_char  <= tcb_pkg::BG_CHAR_RST;
        end else if (cfg_acc) begin
            unique case (i_cfg.index)
                tcb_pkg::REG_COLS:    r_cfg_cols <= i_cfg.data[tcb_pkg::COLS_W-1:0];
                tcb_pkg::REG_ROWS:    r_cfg_rows <= i_cfg.data[tcb_pkg::ROWS_W-1:0];
                tcb_pkg::REG_BG_CHAR: r_bg_char  <= i_cfg.data[tcb_pkg::CHAR_W-1:0];
                default: ;
            endcase
        end
    end

    assign fill.start     = cfg_acc && (i_cfg.index == tcb_pkg::REG_BG_CHAR);
    assign fill.fill_char = r_bg_char;

    // window size, zero acts as one and oversize as the store size
    always_comb begin
        if (r_cfg_cols == '0) begin
            win_cols = tcb_pkg::COLS_W'(1);
        end else if (r_cfg_cols > tcb_pkg::COLS_W'(tcb_pkg::MAX_COLS)) begin
            win_cols = tcb_pkg::COLS_W'(tcb_pkg::MAX_COLS);
        end else begin
            win_cols = r_cfg_cols;
        end
        if (r_cfg_rows == '0) begin
            win_rows = tcb_pkg::ROWS_W'(1);
        end else if (r_cfg_rows > tcb_pkg::ROWS_W'(tcb_pkg::MAX_ROWS)) begin
            win_rows = tcb_pkg::ROWS_W'(tcb_pkg::MAX_ROWS);
        end else begin
            win_rows = r_cfg_rows;
        end
    end

    // handshakes: the input stage moves on whenever the result stage can take a word
    assign fire       = r_in_v && (!r_out_v || o_out.ready);
    assign i_in.ready = !store_busy && (!r_in_v || fire);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (i_in.ready) begin
            r_in_v <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in.action    <= i_in.action;
            r_in.char_code <= i_in.char_code;
            r_in.col_index <= i_in.col_index;
            r_in.row_index <= i_in.row_index;
            r_in.col_delta <= i_in.col_delta;
            r_in.row_delta <= i_in.row_delta;
        end
    end

    // cursor, margin and indexes pulled into the current window
    assign cc = sat_col(r_cur_col, win_cols);
    assign cr = sat_row(r_cur_row, win_rows);
    assign mc = sat_col(r_margin, win_cols);
    assign ci = sat_col(r_in.col_index, win_cols);
    assign ri = sat_row(r_in.row_index, win_rows);

    assign is_print = (r_in.char_code != tcb_pkg::CHAR_NUL)
                   && (r_in.char_code != tcb_pkg::CHAR_LF)
                   && (r_in.char_code != tcb_pkg::CHAR_CR);

    // advance, offset sums and row step
    assign col_inc = {1'b0, cc} + 1'b1;
    assign row_inc = {1'b0, cr} + 1'b1;
    assign put_row = (col_inc >= win_cols) ? row_inc : {1'b0, cr};
    assign p_col   = $signed({3'b000, cc}) + PCOL_W'(r_in.col_delta);
    assign p_row   = $signed({3'b000, cr}) + PROW_W'(r_in.row_delta);

    // next cursor state
    always_comb begin
        n_cur_col = cc;
        n_cur_row = cr;
        n_margin  = mc;
        unique case (r_in.action)
            tcb_pkg::ACT_PUT: begin
                if (r_in.char_code == tcb_pkg::CHAR_LF) begin
                    n_cur_col = mc;
                    n_cur_row = (row_inc >= win_rows) ? '0 : row_inc[tcb_pkg::ROW_W-1:0];
                end else if (r_in.char_code == tcb_pkg::CHAR_CR) begin
                    n_cur_col = mc;
                end else if (is_print) begin
                    n_cur_col = (col_inc >= win_cols) ? mc : col_inc[tcb_pkg::COL_W-1:0];
                    n_cur_row = (put_row >= win_rows) ? '0 : put_row[tcb_pkg::ROW_W-1:0];
                end
            end
            tcb_pkg::ACT_SET: begin
                n_cur_col = ci;
                n_cur_row = ri;
                n_margin  = ci;
            end
            tcb_pkg::ACT_MOVE: begin
                if (p_col[PCOL_W-1]) begin
                    n_cur_col = '0;
                end else if (p_col[PCOL_W-2:0] >= (PCOL_W-1)'(win_cols)) begin
                    n_cur_col = sat_col({tcb_pkg::COL_W{1'b1}}, win_cols);
                end else begin
                    n_cur_col = p_col[tcb_pkg::COL_W-1:0];
                end
                if (p_row[PROW_W-1]) begin
                    n_cur_row = '0;
                end else if (p_row[PROW_W-2:0] >= (PROW_W-1)'(win_rows)) begin
                    n_cur_row = sat_row({tcb_pkg::ROW_W{1'b1}}, win_rows);
                end else begin
                    n_cur_row = p_row[tcb_pkg::ROW_W-1:0];
                end
                n_margin = n_cur_col;
            end
            tcb_pkg::ACT_READ: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_col <= '0;
            r_cur_row <= '0;
            r_margin  <= '0;
        end else if (fire) begin
            r_cur_col <= n_cur_col;
            r_cur_row <= n_cur_row;
            r_margin  <= n_margin;
        end
    end

    // store access: row-major address, a row is MAX_COLS locations
    assign mem_req.wr_en   = fire && (r_in.action == tcb_pkg::ACT_PUT) && is_print;
    assign mem_req.wr_addr = {cr, cc};
    assign mem_req.wr_data = r_in.char_code;
    assign mem_req.rd_en   = fire && (r_in.action == tcb_pkg::ACT_READ);
    assign mem_req.rd_addr = {ri, ci};

    tcb_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mem_req),
        .i_fill    (fill),
        .o_busy    (store_busy),
        .o_rd_data (rd_data)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (fire) begin
            r_out_v <= 1'b1;
        end else if (o_out.ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_rd  <= (r_in.action == tcb_pkg::ACT_READ);
            r_out_col <= n_cur_col;
            r_out_row <= n_cur_row;
        end
    end

    assign o_out.valid      = r_out_v;
    assign o_out.cell_char  = r_out_rd ? rd_data : tcb_pkg::CHAR_NUL;
    assign o_out.cursor_col = r_out_col;
    assign o_out.cursor_row = r_out_row;

endmodule

### rtl/core/tcb_store.sv
// ----------------------------------------------------------------------------
// tcb_store
// character store with one write and one registered read port, plus the
// sweep that fills every location with the background character
// ----------------------------------------------------------------------------
module tcb_store (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  tcb_pkg::t_mem_req          i_req,
    input  tcb_pkg::t_fill             i_fill,
    output logic                       o_busy,
    output logic [tcb_pkg::CHAR_W-1:0] o_rd_data
);

    logic [tcb_pkg::CHAR_W-1:0] r_mem [tcb_pkg::DEPTH];
    logic                       r_busy;
    logic [tcb_pkg::ADDR_W-1:0] r_fill_addr;
    logic [tcb_pkg::CHAR_W-1:0] r_rd_data;

    // fill sweep control: one location a cycle from address zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b1;
            r_fill_addr <= '0;
        end else if (i_fill.start) begin
            r_busy      <= 1'b1;
            r_fill_addr <= '0;
        end else if (r_busy) begin
            r_fill_addr <= r_fill_addr + 1'b1;
            if (&r_fill_addr) begin
                r_busy <= 1'b0;
            end
        end
    end

    // single write port, shared by the sweep and the cursor writes
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_fill_addr] <= i_fill.fill_char;
        end else if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // registered read, held until the next read
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_busy    = r_busy;
    assign o_rd_data = r_rd_data;

endmodule

### rtl/core/tcb_checker.sv
// ----------------------------------------------------------------------------
// tcb_checker
// port-level checks on the text cell buffer, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcb_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [tcb_pkg::CHAR_W-1:0]  i_out_char,
    input logic [tcb_pkg::COL_W-1:0]   i_out_col,
    input logic [tcb_pkg::ROW_W-1:0]   i_out_row,
    input logic                        i_cfg_valid,
    input logic                        i_cfg_ready,
    input logic [tcb_pkg::REG_W-1:0]   i_cfg_index
);

    logic in_acc;
    logic bg_wr;

    assign in_acc = i_in_valid && i_in_ready;
    assign bg_wr  = i_cfg_valid && i_cfg_ready && (i_cfg_index == tcb_pkg::REG_BG_CHAR);

    // a stalled result word holds
    `TCB_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_char) && $stable(i_out_col) && $stable(i_out_row), "result word changed while stalled")

    // an accepted word yields a result once the result side is free
    `TCB_ASSERT(a_result_due, i_clk, i_rst_n, in_acc ##1 (!i_out_valid || i_out_ready) |=> i_out_valid, "accepted word produced no result")

    // reset starts the fill sweep, so no word is taken straight after it
    `TCB_ASSERT_RST(a_rst_fill, i_clk, !i_rst_n |=> !i_in_ready, "command taken during fill after reset")

    // a background write starts a refill of the store
    `TCB_ASSERT(a_bg_fill, i_clk, i_rst_n, bg_wr |=> !i_in_ready, "command taken during refill")

endmodule

bind text_cell_buffer_cursor_writer_top tcb_checker u_tcb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_char  (o_out.cell_char),
    .i_out_col   (o_out.cursor_col),
    .i_out_row   (o_out.cursor_row),
    .i_cfg_valid (i_cfg.valid),
    .i_cfg_ready (i_cfg.ready),
    .i_cfg_index (i_cfg.index)
);
